// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// shared concurrent assertion macros, clocked on clk, off while in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== hdl/efr_pkg.sv =====
// ----------------------------------------------------------------------------
// efr_pkg
// types and constants of the edge function triangle raster core
// ----------------------------------------------------------------------------
`default_nettype none

package efr_pkg;

  localparam int COORD_BITS = 12;
  localparam int BOX_BITS   = COORD_BITS + 1;
  localparam int EDGE_BITS  = 32;
  localparam int COLOR_BITS = 32;
  localparam int PIX_BITS   = 11;
  localparam int LERR_BITS  = COORD_BITS + 4;

  localparam logic [COORD_BITS-1:0] FRAME_W_RESET = COORD_BITS'(640);
  localparam logic [COORD_BITS-1:0] FRAME_H_RESET = COORD_BITS'(480);

  typedef enum logic {
    KIND_START   = 1'b0,
    KIND_ADVANCE = 1'b1
  } kind_t;

  typedef enum logic {
    REG_FRAME_W = 1'b0,
    REG_FRAME_H = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_FILL  = 3'd1,
    PH_LINE0 = 3'd2,
    PH_LINE1 = 3'd3,
    PH_LINE2 = 3'd4,
    PH_DONE  = 3'd5
  } phase_t;

  typedef struct packed {
    logic                         steep;
    logic                         down;
    logic signed [COORD_BITS-1:0] major;
    logic signed [COORD_BITS-1:0] minor;
    logic signed [COORD_BITS-1:0] mend;
    logic signed [LERR_BITS-1:0]  err;
    logic signed [LERR_BITS-1:0]  inc_keep;
    logic signed [LERR_BITS-1:0]  inc_step;
  } line_t;

  typedef struct packed {
    logic                       empty;
    logic signed [BOX_BITS-1:0] min_x;
    logic signed [BOX_BITS-1:0] min_y;
    logic signed [BOX_BITS-1:0] max_x;
    logic signed [BOX_BITS-1:0] max_y;
  } box_t;

endpackage

`default_nettype wire

// ===== hdl/efr_line_setup.sv =====
// ----------------------------------------------------------------------------
// efr_line_setup
// bresenham setup: steep swap, endpoint order, error terms
// ----------------------------------------------------------------------------
`default_nettype none

module efr_line_setup
  import efr_pkg::*;
(
  input  logic signed [COORD_BITS-1:0] p1_x,
  input  logic signed [COORD_BITS-1:0] p1_y,
  input  logic signed [COORD_BITS-1:0] p2_x,
  input  logic signed [COORD_BITS-1:0] p2_y,
  output line_t                        line
);

  logic signed [COORD_BITS:0]   ddx, ddy, adx, ady, dxl, dyd, dyl;
  logic                         steep;
  logic signed [COORD_BITS-1:0] s1x, s1y, s2x, s2y, ax, ay, bx, by;
  logic signed [LERR_BITS-1:0]  dx16, dy16, keep;

  always_comb begin
    ddx   = {p2_x[COORD_BITS-1], p2_x} - {p1_x[COORD_BITS-1], p1_x};
    ddy   = {p2_y[COORD_BITS-1], p2_y} - {p1_y[COORD_BITS-1], p1_y};
    adx   = ddx[COORD_BITS] ? -ddx : ddx;
    ady   = ddy[COORD_BITS] ? -ddy : ddy;
    steep = ady > adx;
    s1x   = steep ? p1_y : p1_x;
    s1y   = steep ? p1_x : p1_y;
    s2x   = steep ? p2_y : p2_x;
    s2y   = steep ? p2_x : p2_y;
    if (s1x > s2x) begin
      ax = s2x; ay = s2y; bx = s1x; by = s1y;
    end else begin
      ax = s1x; ay = s1y; bx = s2x; by = s2y;
    end
    dxl  = {bx[COORD_BITS-1], bx} - {ax[COORD_BITS-1], ax};
    dyd  = {by[COORD_BITS-1], by} - {ay[COORD_BITS-1], ay};
    dyl  = dyd[COORD_BITS] ? -dyd : dyd;
    dx16 = LERR_BITS'(dxl);
    dy16 = LERR_BITS'(dyl);
    keep = dy16 + dy16;
    line.steep    = steep;
    line.down     = ay > by;
    line.major    = ax;
    line.minor    = ay;
    line.mend     = bx;
    line.inc_keep = keep;
    line.inc_step = keep - dx16 - dx16;
    line.err      = keep - dx16;
  end

endmodule

`default_nettype wire

// ===== hdl/efr_setup.sv =====
// ----------------------------------------------------------------------------
// efr_setup
// clipped bounding box and edge function values at the box corner
// ----------------------------------------------------------------------------
`default_nettype none

module efr_setup
  import efr_pkg::*;
(
  input  logic signed [COORD_BITS-1:0] vx [3],
  input  logic signed [COORD_BITS-1:0] vy [3],
  input  logic        [COORD_BITS-1:0] frame_w,
  input  logic        [COORD_BITS-1:0] frame_h,
  output box_t                         box,
  output logic signed [EDGE_BITS-1:0]  edge_val [3],
  output logic signed [COORD_BITS:0]   step_x [3],
  output logic signed [COORD_BITS:0]   step_y [3]
);

  logic signed [COORD_BITS-1:0] mnx, mxx, mny, mxy;
  logic signed [BOX_BITS-1:0]   lim_x, lim_y, bmin_x, bmin_y, bmax_x, bmax_y;

  always_comb begin
    mnx = (vx[0] < vx[1]) ? vx[0] : vx[1];
    mnx = (vx[2] < mnx) ? vx[2] : mnx;
    mxx = (vx[0] > vx[1]) ? vx[0] : vx[1];
    mxx = (vx[2] > mxx) ? vx[2] : mxx;
    mny = (vy[0] < vy[1]) ? vy[0] : vy[1];
    mny = (vy[2] < mny) ? vy[2] : mny;
    mxy = (vy[0] > vy[1]) ? vy[0] : vy[1];
    mxy = (vy[2] > mxy) ? vy[2] : mxy;
    lim_x  = $signed({1'b0, frame_w}) - BOX_BITS'(1);
    lim_y  = $signed({1'b0, frame_h}) - BOX_BITS'(1);
    bmin_x = mnx[COORD_BITS-1] ? '0 : BOX_BITS'(mnx);
    bmin_y = mny[COORD_BITS-1] ? '0 : BOX_BITS'(mny);
    bmax_x = (BOX_BITS'(mxx) < lim_x) ? BOX_BITS'(mxx) : lim_x;
    bmax_y = (BOX_BITS'(mxy) < lim_y) ? BOX_BITS'(mxy) : lim_y;
    box.min_x = bmin_x;
    box.min_y = bmin_y;
    box.max_x = bmax_x;
    box.max_y = bmax_y;
    box.empty = (bmax_x < bmin_x) || (bmax_y < bmin_y);
  end

  // edge value at the corner, taken relative to the edge start vertex
  for (genvar i = 0; i < 3; i++) begin : g_edge
    localparam int N = (i + 1) % 3;
    logic signed [COORD_BITS:0]     ea, eb;
    logic signed [COORD_BITS+1:0]   ox, oy;
    logic signed [2*COORD_BITS+2:0] px, py;
    logic signed [2*COORD_BITS+3:0] sum;
    always_comb begin
      ea  = {vy[i][COORD_BITS-1], vy[i]} - {vy[N][COORD_BITS-1], vy[N]};
      eb  = {vx[N][COORD_BITS-1], vx[N]} - {vx[i][COORD_BITS-1], vx[i]};
      ox  = (COORD_BITS+2)'(bmin_x) - (COORD_BITS+2)'(vx[i]);
      oy  = (COORD_BITS+2)'(bmin_y) - (COORD_BITS+2)'(vy[i]);
      px  = ea * ox;
      py  = eb * oy;
      sum = (2*COORD_BITS+4)'(px) + (2*COORD_BITS+4)'(py);
      edge_val[i] = EDGE_BITS'(sum);
      step_x[i]   = ea;
      step_y[i]   = eb;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/edge_function_triangle_raster_core.sv =====
// ----------------------------------------------------------------------------
// edge_function_triangle_raster_core
// triangle fill by edge functions, then three bresenham outline lines
// ----------------------------------------------------------------------------
// A start transfer latches the triangle and produces no result; each advance
// transfer produces exactly one candidate pixel, valid on the output in the
// cycle after it is accepted. Setup, box walk and line stepping are direct
// updates of the state registers. A new item is taken in any cycle in which
// the output register is empty or its result is taken in that same cycle;
// a result that waits holds off the input.
// Advances beyond the last outline pixel return done with no write.
`default_nettype none

module edge_function_triangle_raster_core
  import efr_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic        [COORD_BITS-1:0] cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_kind,
  input  logic signed [COORD_BITS-1:0] in_vert_a_x,
  input  logic signed [COORD_BITS-1:0] in_vert_a_y,
  input  logic signed [COORD_BITS-1:0] in_vert_b_x,
  input  logic signed [COORD_BITS-1:0] in_vert_b_y,
  input  logic signed [COORD_BITS-1:0] in_vert_c_x,
  input  logic signed [COORD_BITS-1:0] in_vert_c_y,
  input  logic        [COLOR_BITS-1:0] in_fill_color,
  input  logic        [COLOR_BITS-1:0] in_outline_color,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_write_enable,
  output logic        [PIX_BITS-1:0]   out_pixel_x,
  output logic        [PIX_BITS-1:0]   out_pixel_y,
  output logic        [COLOR_BITS-1:0] out_pixel_color,
  output logic                         out_done_res
);

  `include "assert_macros.svh"

  phase_t                       phase_r, phase_nxt;
  logic                         out_valid_r;
  logic        [COORD_BITS-1:0] frame_w_r, frame_h_r;
  logic signed [COORD_BITS-1:0] vx_r [3];
  logic signed [COORD_BITS-1:0] vy_r [3];
  logic signed [COORD_BITS-1:0] in_vx [3];
  logic signed [COORD_BITS-1:0] in_vy [3];
  logic        [COLOR_BITS-1:0] fill_col_r, line_col_r;
  logic signed [BOX_BITS-1:0]   scan_x_r, scan_y_r, min_x_r, max_x_r, max_y_r;
  logic signed [EDGE_BITS-1:0]  row_r [3];
  logic signed [EDGE_BITS-1:0]  cur_r [3];
  logic signed [COORD_BITS:0]   stx_r [3];
  logic signed [COORD_BITS:0]   sty_r [3];
  line_t                        ln_r, ln_setup;

  box_t                         su_box;
  logic signed [EDGE_BITS-1:0]  su_edge [3];
  logic signed [COORD_BITS:0]   su_stx [3];
  logic signed [COORD_BITS:0]   su_sty [3];

  logic signed [COORD_BITS-1:0] p1x, p1y, p2x, p2y, rx, ry;
  logic in_acc, is_start, is_adv, in_tri, row_end, fill_last, line_last, line_ok;
  logic                         res_we, res_done;
  logic        [PIX_BITS-1:0]   res_x, res_y;
  logic        [COLOR_BITS-1:0] res_col;
  logic                         we_r, done_r;
  logic        [PIX_BITS-1:0]   px_r, py_r;
  logic        [COLOR_BITS-1:0] col_r;

  assign in_ready  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign is_start  = in_acc && (in_kind == KIND_START);
  assign is_adv    = in_acc && (in_kind == KIND_ADVANCE);

  assign in_vx[0] = in_vert_a_x;
  assign in_vx[1] = in_vert_b_x;
  assign in_vx[2] = in_vert_c_x;
  assign in_vy[0] = in_vert_a_y;
  assign in_vy[1] = in_vert_b_y;
  assign in_vy[2] = in_vert_c_y;

  efr_setup u_setup (
    .vx       (in_vx),
    .vy       (in_vy),
    .frame_w  (frame_w_r),
    .frame_h  (frame_h_r),
    .box      (su_box),
    .edge_val (su_edge),
    .step_x   (su_stx),
    .step_y   (su_sty)
  );

  efr_line_setup u_line (
    .p1_x (p1x),
    .p1_y (p1y),
    .p2_x (p2x),
    .p2_y (p2y),
    .line (ln_setup)
  );

  always_comb begin
    if (is_start) begin
      p1x = in_vert_a_x; p1y = in_vert_a_y; p2x = in_vert_b_x; p2y = in_vert_b_y;
    end else begin
      unique case (phase_r)
        PH_LINE0: begin
          p1x = vx_r[1]; p1y = vy_r[1]; p2x = vx_r[2]; p2y = vy_r[2];
        end
        PH_LINE1: begin
          p1x = vx_r[2]; p1y = vy_r[2]; p2x = vx_r[0]; p2y = vy_r[0];
        end
        default: begin
          p1x = vx_r[0]; p1y = vy_r[0]; p2x = vx_r[1]; p2y = vy_r[1];
        end
      endcase
    end
  end

  always_comb begin
    in_tri    = !cur_r[0][EDGE_BITS-1] && !cur_r[1][EDGE_BITS-1] &&
                !cur_r[2][EDGE_BITS-1];
    row_end   = scan_x_r >= max_x_r;
    fill_last = row_end && (scan_y_r >= max_y_r);
    line_last = ln_r.major >= ln_r.mend;
    rx        = ln_r.steep ? ln_r.minor : ln_r.major;
    ry        = ln_r.steep ? ln_r.major : ln_r.minor;
    line_ok   = !rx[COORD_BITS-1] && !ry[COORD_BITS-1] &&
                (unsigned'(rx) < frame_w_r) && (unsigned'(ry) < frame_h_r);
    phase_nxt = phase_r;
    res_we    = 1'b0;
    res_x     = '0;
    res_y     = '0;
    res_col   = '0;
    res_done  = 1'b0;
    if (is_start) begin
      phase_nxt = su_box.empty ? PH_LINE0 : PH_FILL;
    end else begin
      unique case (phase_r)
        PH_FILL: begin
          res_we = in_tri;
          if (fill_last) begin
            phase_nxt = PH_LINE0;
          end
        end
        PH_LINE0, PH_LINE1, PH_LINE2: begin
          res_we = line_ok;
          if (line_last) begin
            unique case (phase_r)
              PH_LINE0: phase_nxt = PH_LINE1;
              PH_LINE1: phase_nxt = PH_LINE2;
              default: begin
                phase_nxt = PH_DONE;
                res_done  = 1'b1;
              end
            endcase
          end
        end
        default: begin
          res_done = 1'b1;
        end
      endcase
      if (res_we) begin
        if (phase_r == PH_FILL) begin
          res_x   = PIX_BITS'(scan_x_r);
          res_y   = PIX_BITS'(scan_y_r);
          res_col = fill_col_r;
        end else begin
          res_x   = PIX_BITS'(rx);
          res_y   = PIX_BITS'(ry);
          res_col = line_col_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      out_valid_r <= 1'b0;
      frame_w_r   <= FRAME_W_RESET;
      frame_h_r   <= FRAME_H_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (reg_idx_t'(cfg_index))
          REG_FRAME_W: frame_w_r <= cfg_data;
          REG_FRAME_H: frame_h_r <= cfg_data;
          default: ;
        endcase
      end
      if (in_acc) begin
        phase_r <= phase_nxt;
      end
      if (is_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_adv) begin
      we_r   <= res_we;
      px_r   <= res_x;
      py_r   <= res_y;
      col_r  <= res_col;
      done_r <= res_done;
    end
    if (is_start) begin
      for (int i = 0; i < 3; i++) begin
        vx_r[i]  <= in_vx[i];
        vy_r[i]  <= in_vy[i];
        row_r[i] <= su_edge[i];
        cur_r[i] <= su_edge[i];
        stx_r[i] <= su_stx[i];
        sty_r[i] <= su_sty[i];
      end
      fill_col_r <= in_fill_color;
      line_col_r <= in_outline_color;
      min_x_r    <= su_box.min_x;
      max_x_r    <= su_box.max_x;
      max_y_r    <= su_box.max_y;
      scan_x_r   <= su_box.min_x;
      scan_y_r   <= su_box.min_y;
      if (su_box.empty) begin
        ln_r <= ln_setup;
      end
    end else if (is_adv) begin
      if (phase_r == PH_FILL) begin
        if (fill_last) begin
          ln_r <= ln_setup;
        end else if (row_end) begin
          scan_y_r <= scan_y_r + BOX_BITS'(1);
          scan_x_r <= min_x_r;
          for (int i = 0; i < 3; i++) begin
            row_r[i] <= row_r[i] + EDGE_BITS'(sty_r[i]);
            cur_r[i] <= row_r[i] + EDGE_BITS'(sty_r[i]);
          end
        end else begin
          scan_x_r <= scan_x_r + BOX_BITS'(1);
          for (int i = 0; i < 3; i++) begin
            cur_r[i] <= cur_r[i] + EDGE_BITS'(stx_r[i]);
          end
        end
      end else if (phase_r == PH_LINE0 || phase_r == PH_LINE1 ||
                   phase_r == PH_LINE2) begin
        if (line_last) begin
          if (phase_r != PH_LINE2) begin
            ln_r <= ln_setup;
          end
        end else begin
          ln_r.major <= ln_r.major + COORD_BITS'(1);
          if (!ln_r.err[LERR_BITS-1]) begin
            ln_r.err   <= ln_r.err + ln_r.inc_step;
            ln_r.minor <= ln_r.down ? ln_r.minor - COORD_BITS'(1)
                                    : ln_r.minor + COORD_BITS'(1);
          end else begin
            ln_r.err <= ln_r.err + ln_r.inc_keep;
          end
        end
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_write_enable = we_r;
  assign out_pixel_x      = px_r;
  assign out_pixel_y      = py_r;
  assign out_pixel_color  = col_r;
  assign out_done_res     = done_r;

  `ASSERT_ALWAYS(a_nowrite_zero, !(out_valid_r && !we_r) || (px_r == '0 && py_r == '0 && col_r == '0), "pixel fields not zero without write")
  `ASSERT_ALWAYS(a_scan_in_box, !(phase_r == PH_FILL) || (scan_x_r <= max_x_r && scan_y_r <= max_y_r), "scan left the box")
  `ASSERT_NEXT(a_done_sticky, is_adv && (phase_r == PH_DONE || phase_r == PH_IDLE), out_valid_r && done_r && !we_r, "idle advance not reported done")
  `ASSERT_NEXT(a_fill_nodone, is_adv && phase_r == PH_FILL, !done_r, "done raised during fill")

endmodule

`default_nettype wire
